// File: design/bpm_pkg.sv
// Shared types and constants for the buffer pool mailbox.
// Holds the word formats, operation and status codes, and the
// command/status structs between controller and datapath. No dependencies.
package bpm_pkg;

  localparam int NUM_BUFFERS = 16;
  localparam int IDX_W       = 4;
  localparam int LEN_W       = 16;
  localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 3;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(16);

  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEND  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RECV  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DRAIN = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd5;

  localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STS_BAD_LENGTH = 3'd1;
  localparam logic [STATUS_W-1:0] STS_POOL_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_OWNED  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_RING_FULL  = 3'd4;
  localparam logic [STATUS_W-1:0] STS_RING_EMPTY = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  buffer_index;
    logic [LEN_W-1:0]  length;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    buffer_index_out;
    logic [LEN_W-1:0]    length_out;
    logic [CNT_W-1:0]    free_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request word into the op register
    logic commit;      // execute op and write the response register
    logic drain_step;  // pop one ring entry and recycle it if it is owned
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic drain_op;
    logic ring_empty;
    logic out_free;
  } stat_t;

endpackage

// File: design/bpm_datapath.sv
// Datapath of the buffer pool mailbox: free stack, owned flags, lengths,
// index ring memory, ring pointers and the response register.
// Depends on bpm_pkg; driven by bpm_controller commands.
module bpm_datapath
  import bpm_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  req_t             req,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int OCC_W = $clog2(RING_DEPTH + 1);

  logic [LEN_W-1:0] max_length;
  req_t             op;

  logic [IDX_W-1:0] free_stack [NUM_BUFFERS];
  logic [CNT_W-1:0] free_top, free_top_next;
  logic [NUM_BUFFERS-1:0] owned;
  logic [LEN_W-1:0] lengths [NUM_BUFFERS];

  logic [IDX_W-1:0] ring [RING_DEPTH];
  logic [IDX_W-1:0] rd_q;
  logic [PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_next, rd_ptr_next;
  logic [OCC_W-1:0] occ;

  logic             stk_we;
  logic [IDX_W-1:0] stk_addr, stk_wdata;
  logic             own_we, own_val;
  logic [IDX_W-1:0] own_addr;
  logic             len_we;
  logic [IDX_W-1:0] len_addr;
  logic [LEN_W-1:0] len_wdata;
  logic             ring_we, rd_adv;

  logic [CNT_W-1:0] top_m1;
  logic [IDX_W-1:0] pop_idx, rec_idx;
  logic             can_rec, len_over;
  rsp_t             res;

  assign top_m1   = free_top - 1'b1;
  assign pop_idx  = free_stack[top_m1[IDX_W-1:0]];
  assign rec_idx  = cmd.drain_step ? rd_q : op.buffer_index;
  assign can_rec  = owned[rec_idx] && (free_top < CNT_W'(NUM_BUFFERS));
  assign len_over = op.length > max_length;

  assign wr_ptr_next = !ring_we ? wr_ptr :
                       (wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = !rd_adv ? rd_ptr :
                       (rd_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_comb begin
    free_top_next = free_top;
    stk_we        = 1'b0;
    stk_addr      = free_top[IDX_W-1:0];
    stk_wdata     = rec_idx;
    own_we        = 1'b0;
    own_val       = 1'b0;
    own_addr      = rec_idx;
    len_we        = 1'b0;
    len_addr      = op.buffer_index;
    len_wdata     = op.length;
    ring_we       = 1'b0;
    rd_adv        = 1'b0;
    res           = '0;
    res.status    = STS_OK;

    if (cmd.commit) begin
      case (op.mode)
        MODE_ALLOC: begin
          if (len_over) begin
            res.status = STS_BAD_LENGTH;
          end else if (free_top == '0) begin
            res.status = STS_POOL_EMPTY;
          end else begin
            free_top_next        = top_m1;
            own_we               = 1'b1;
            own_val              = 1'b1;
            own_addr             = pop_idx;
            len_we               = 1'b1;
            len_addr             = pop_idx;
            len_wdata            = '0;
            res.buffer_index_out = pop_idx;
          end
        end
        MODE_FREE: begin
          if (can_rec) begin
            own_we        = 1'b1;
            stk_we        = 1'b1;
            free_top_next = free_top + 1'b1;
          end else begin
            res.status = STS_NOT_OWNED;
          end
        end
        MODE_SEND: begin
          if (op.length == '0 || len_over) begin
            res.status = STS_BAD_LENGTH;
          end else if (!owned[op.buffer_index]) begin
            res.status = STS_NOT_OWNED;
          end else if (occ == OCC_W'(RING_DEPTH)) begin
            res.status = STS_RING_FULL;
          end else begin
            len_we         = 1'b1;
            ring_we        = 1'b1;
            res.length_out = op.length;
          end
        end
        MODE_RECV: begin
          if (occ == '0) begin
            res.status = STS_RING_EMPTY;
          end else begin
            rd_adv               = 1'b1;
            res.buffer_index_out = rd_q;
            res.length_out       = lengths[rd_q];
          end
        end
        default: begin
          // drain end, query and unused codes only report the count
        end
      endcase
    end else if (cmd.drain_step) begin
      rd_adv = 1'b1;
      if (can_rec) begin
        own_we        = 1'b1;
        stk_we        = 1'b1;
        free_top_next = free_top + 1'b1;
      end
    end
    res.free_count = free_top_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
      free_top   <= CNT_W'(NUM_BUFFERS);
      owned      <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      occ        <= '0;
      rsp_valid  <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        free_stack[i] <= IDX_W'(i);
      end
    end else begin
      if (cfg_we) begin
        max_length <= cfg_wdata;
      end
      free_top <= free_top_next;
      if (own_we) begin
        owned[own_addr] <= own_val;
      end
      if (stk_we) begin
        free_stack[stk_addr] <= stk_wdata;
      end
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      if (ring_we) begin
        occ <= occ + 1'b1;
      end else if (rd_adv) begin
        occ <= occ - 1'b1;
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req;
    end
    if (len_we) begin
      lengths[len_addr] <= len_wdata;
    end
    if (cmd.commit) begin
      rsp <= res;
    end
  end

  // index ring: one write port, registered read at the next read pointer
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wr_ptr] <= op.buffer_index;
    end
    rd_q <= ring[rd_ptr_next];
  end

  assign stat.drain_op   = (op.mode == MODE_DRAIN);
  assign stat.ring_empty = (occ == '0);
  assign stat.out_free   = !rsp_valid || rsp_ready;

  // every buffer is either on the free stack or owned
  a_pool_conserved: assert property (@(posedge clk) disable iff (rst)
    ($countones(owned) + int'(free_top)) == NUM_BUFFERS)
    else $error("owned flags and free stack disagree");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    int'(occ) <= RING_DEPTH)
    else $error("ring occupancy out of range");

endmodule

// File: design/bpm_controller.sv
// Controller of the buffer pool mailbox: sequences accept, execute
// and ring drain. Depends on bpm_pkg; drives bpm_datapath.
module bpm_controller
  import bpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        // no word is taken while reset is held
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.drain_op && !stat.ring_empty) begin
          cmd.drain_step = 1'b1;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("response written while the slot is full");

  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EXEC))
    else $error("accepted word not executed");

endmodule

// File: design/buffer_pool_mailbox_unit.sv
// Buffer pool mailbox: a LIFO free list of 16 buffers plus a ring of indices.
// Each accepted word is executed before the next is accepted: the controller
// accepts in S_IDLE and executes in S_EXEC; drain first pops the ring, one
// ring entry per cycle, then commits. A commit waits while a response is
// pending, but a pending response does not block the next accept.
// Sync reset: all buffers free, ring empty, max_length 16; no clearing pass.
module buffer_pool_mailbox_unit
  import bpm_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  cmd_t  cmd;
  stat_t stat;

  bpm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpm_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
